// ===== rtl/cii_pkg.sv =====
`timescale 1ns / 1ps

package cii_pkg;

    // Field widths of the stream words
    localparam int WL_W   = 18;
    localparam int IX_W   = 17;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;
    localparam int RC_W   = 2;
    localparam int ACC_W  = IX_W + WL_W;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    // One quotient bit per divider step
    localparam int DIV_STEPS = IX_W;

    localparam logic [CNT_W-1:0] ROWS_RESET = 6'd22;

    // Word kinds on the input stream
    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    // Range codes on the output stream
    localparam logic [RC_W-1:0] RC_INTERP = 2'd0;
    localparam logic [RC_W-1:0] RC_BELOW  = 2'd1;
    localparam logic [RC_W-1:0] RC_ABOVE  = 2'd2;

    // One table row as stored in the RAM
    typedef struct packed {
        logic [IX_W-1:0] im;
        logic [IX_W-1:0] re;
        logic [WL_W-1:0] bp;
    } row_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_QUOT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_LAST,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [2:0] {
        RES_FIRST,
        RES_RDATA,
        RES_PREV,
        RES_ONE,
        RES_QUOT
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic            load_row;
        logic            take_query;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            first_cap;
        logic            prev_cap;
        logic            cnt_inc;
        logic            seg_cap;
        logic            mul_a;
        logic            mul_b;
        logic            div_load;
        logic            div_step;
        logic            res_cap;
        res_sel_t        res_sel;
        logic [RC_W-1:0] res_rc;
        logic            out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic below;
        logic above;
        logic hit;
        logic zero_w;
        logic at_end;
    } sts_t;

endpackage

// ===== rtl/cii_ram.sv =====
`timescale 1ns / 1ps

module cii_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cii_div.sv =====
`timescale 1ns / 1ps

module cii_div (
    input  logic                       clk,
    input  logic                       load,
    input  logic                       step,
    input  logic [cii_pkg::ACC_W-1:0]  num,
    input  logic [cii_pkg::WL_W-1:0]   den,
    output logic [cii_pkg::IX_W-1:0]   quot
);

    localparam int WLW = cii_pkg::WL_W;
    localparam int IXW = cii_pkg::IX_W;
    localparam int ACW = cii_pkg::ACC_W;

    logic [WLW-1:0] rem_reg;
    logic [WLW-1:0] rem_next;
    logic [IXW-1:0] sh_reg;
    logic [WLW:0]   trial;
    logic [WLW:0]   diff;
    logic           ge;

    // Restoring step: the quotient fits IX_W bits, so the top of the
    // numerator already sits below the divisor
    always_comb
    begin
        trial    = {rem_reg, sh_reg[IXW-1]};
        diff     = trial - {1'b0, den};
        ge       = (trial >= {1'b0, den});
        rem_next = ge ? diff[WLW-1:0] : trial[WLW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= num[ACW-1:IXW];
            sh_reg  <= num[IXW-1:0];
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            sh_reg  <= {sh_reg[IXW-2:0], ge};
        end
    end

    assign quot = sh_reg;

endmodule

// ===== rtl/cii_ctrl.sv =====
`timescale 1ns / 1ps

module cii_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            s_kind,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  cii_pkg::sts_t   sts,
    output cii_pkg::cmd_t   cmd
);

    localparam int DCW = $clog2(cii_pkg::DIV_STEPS);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(cii_pkg::DIV_STEPS - 1);

    cii_pkg::state_t state_reg;
    cii_pkg::state_t state_next;
    logic [DCW-1:0]  div_cnt_reg;
    logic [DCW-1:0]  div_cnt_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cii_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_kind == cii_pkg::KIND_QUERY))
                begin
                    state_next = cii_pkg::ST_FIRST;
                end
            end
            cii_pkg::ST_FIRST:
            begin
                state_next = cii_pkg::ST_LAST;
            end
            cii_pkg::ST_LAST:
            begin
                if (sts.below || sts.above)
                begin
                    state_next = cii_pkg::ST_OUT;
                end
                else
                begin
                    state_next = cii_pkg::ST_SCAN;
                end
            end
            cii_pkg::ST_SCAN:
            begin
                if (sts.hit)
                begin
                    state_next = sts.zero_w ? cii_pkg::ST_OUT : cii_pkg::ST_MUL0;
                end
                else if (sts.at_end)
                begin
                    state_next = cii_pkg::ST_OUT;
                end
            end
            cii_pkg::ST_MUL0:
            begin
                state_next = cii_pkg::ST_MUL1;
            end
            cii_pkg::ST_MUL1:
            begin
                state_next = cii_pkg::ST_MUL2;
            end
            cii_pkg::ST_MUL2:
            begin
                state_next = cii_pkg::ST_DIV;
            end
            cii_pkg::ST_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = cii_pkg::ST_QUOT;
                end
            end
            cii_pkg::ST_QUOT:
            begin
                state_next = cii_pkg::ST_OUT;
            end
            cii_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = cii_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cii_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd         = '0;
        cmd.rd_sel  = cii_pkg::RD_ZERO;
        cmd.res_sel = cii_pkg::RES_FIRST;
        cmd.res_rc  = cii_pkg::RC_INTERP;
        s_tready    = 1'b0;
        case (state_reg)
            cii_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_kind == cii_pkg::KIND_LOAD)
                    begin
                        cmd.load_row = 1'b1;
                    end
                    else
                    begin
                        cmd.take_query = 1'b1;
                        cmd.rd_en      = 1'b1;
                        cmd.rd_sel     = cii_pkg::RD_ZERO;
                    end
                end
            end
            cii_pkg::ST_FIRST:
            begin
                cmd.first_cap = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = cii_pkg::RD_LAST;
            end
            cii_pkg::ST_LAST:
            begin
                if (sts.below)
                begin
                    cmd.res_cap = 1'b1;
                    cmd.res_sel = cii_pkg::RES_FIRST;
                    cmd.res_rc  = cii_pkg::RC_BELOW;
                end
                else if (sts.above)
                begin
                    cmd.res_cap = 1'b1;
                    cmd.res_sel = cii_pkg::RES_RDATA;
                    cmd.res_rc  = cii_pkg::RC_ABOVE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = cii_pkg::RD_NEXT;
                    cmd.cnt_inc = 1'b1;
                end
            end
            cii_pkg::ST_SCAN:
            begin
                if (sts.hit)
                begin
                    if (sts.zero_w)
                    begin
                        cmd.res_cap = 1'b1;
                        cmd.res_sel = cii_pkg::RES_PREV;
                    end
                    else
                    begin
                        cmd.seg_cap = 1'b1;
                    end
                end
                else if (sts.at_end)
                begin
                    cmd.res_cap = 1'b1;
                    cmd.res_sel = cii_pkg::RES_ONE;
                end
                else
                begin
                    cmd.prev_cap = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = cii_pkg::RD_NEXT;
                end
            end
            cii_pkg::ST_MUL0:
            begin
                cmd.mul_a = 1'b1;
            end
            cii_pkg::ST_MUL1:
            begin
                cmd.mul_b = 1'b1;
            end
            cii_pkg::ST_MUL2:
            begin
                cmd.div_load = 1'b1;
            end
            cii_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            cii_pkg::ST_QUOT:
            begin
                cmd.res_cap = 1'b1;
                cmd.res_sel = cii_pkg::RES_QUOT;
            end
            cii_pkg::ST_OUT:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Divider step count and output word valid
    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (state_reg == cii_pkg::ST_MUL2)
        begin
            div_cnt_next = '0;
        end
        else if (state_reg == cii_pkg::ST_DIV)
        begin
            div_cnt_next = div_cnt_reg + DCW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cii_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/cii_datapath.sv =====
`timescale 1ns / 1ps

module cii_datapath #(
    parameter int MAX_ROWS  = 32,
    parameter int FRAC_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cii_pkg::CNT_W-1:0]   cfg_data,
    input  logic [cii_pkg::IDX_W-1:0]   entry_index,
    input  logic [cii_pkg::WL_W-1:0]    wavelength,
    input  logic [cii_pkg::IX_W-1:0]    load_re,
    input  logic [cii_pkg::IX_W-1:0]    load_im,
    input  cii_pkg::cmd_t               cmd,
    output cii_pkg::sts_t               sts,
    output logic [cii_pkg::IX_W-1:0]    index_re,
    output logic [cii_pkg::IX_W-1:0]    index_im,
    output logic [cii_pkg::RC_W-1:0]    range_case
);

    localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (AW + 1 > cii_pkg::CNT_W) ? AW + 1 : cii_pkg::CNT_W;
    localparam int IXW = cii_pkg::IX_W;
    localparam int ACW = cii_pkg::ACC_W;
    localparam int RW  = $bits(cii_pkg::row_t);
    localparam logic [IXW-1:0] ONE_VAL  = IXW'(1 << FRAC_BITS);
    localparam logic [CW-1:0]  ROWS_MAX = CW'(MAX_ROWS);
    localparam logic [CW-1:0]  ROWS_MIN = CW'(2);

    logic [cii_pkg::CNT_W-1:0] rows_cfg_reg;
    logic [CW-1:0]             rows_ext;
    logic [CW-1:0]             rows_clamp;
    logic [CW-1:0]             last_ext;
    logic [AW-1:0]             last_row;
    logic [CW-1:0]             idx_ext;
    logic                      wr_en;
    logic [AW-1:0]             rd_addr;
    cii_pkg::row_t             wr_row;
    cii_pkg::row_t             rd_row;

    logic [cii_pkg::WL_W-1:0]  wl_reg;
    logic [AW-1:0]             cnt_reg;
    cii_pkg::row_t             first_row_reg;
    cii_pkg::row_t             prev_row_reg;
    logic [IXW-1:0]            b_re_reg;
    logic [IXW-1:0]            b_im_reg;
    logic [cii_pkg::WL_W-1:0]  d1_reg;
    logic [cii_pkg::WL_W-1:0]  d2_reg;
    logic [cii_pkg::WL_W-1:0]  w_reg;
    logic [ACW-1:0]            prod_re_reg;
    logic [ACW-1:0]            prod_im_reg;
    logic [ACW-1:0]            acc_re_reg;
    logic [ACW-1:0]            acc_im_reg;
    logic [ACW-1:0]            num_re;
    logic [ACW-1:0]            num_im;
    logic [IXW-1:0]            quot_re;
    logic [IXW-1:0]            quot_im;
    logic [IXW-1:0]            res_re_next;
    logic [IXW-1:0]            res_im_next;
    logic [IXW-1:0]            res_re_reg;
    logic [IXW-1:0]            res_im_reg;
    logic [cii_pkg::RC_W-1:0]  res_rc_reg;
    logic [IXW-1:0]            out_re_reg;
    logic [IXW-1:0]            out_im_reg;
    logic [cii_pkg::RC_W-1:0]  out_rc_reg;

    // Row count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= cii_pkg::ROWS_RESET;
        end
        else if (cfg_we)
        begin
            rows_cfg_reg <= cfg_data;
        end
    end

    // Clamp the row count and derive the last row used
    always_comb
    begin
        rows_ext = CW'(rows_cfg_reg);
        if (rows_ext < ROWS_MIN)
        begin
            rows_clamp = ROWS_MIN;
        end
        else if (rows_ext > ROWS_MAX)
        begin
            rows_clamp = ROWS_MAX;
        end
        else
        begin
            rows_clamp = rows_ext;
        end
        last_ext = rows_clamp - CW'(1);
        last_row = last_ext[AW-1:0];
    end

    // Table write; rows past the table are dropped
    assign idx_ext   = CW'(entry_index);
    assign wr_en     = cmd.load_row && (idx_ext < ROWS_MAX);
    assign wr_row.bp = wavelength;
    assign wr_row.re = load_re;
    assign wr_row.im = load_im;

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            cii_pkg::RD_ZERO: rd_addr = '0;
            cii_pkg::RD_LAST: rd_addr = last_row;
            cii_pkg::RD_NEXT: rd_addr = cnt_reg + AW'(1);
            default:          rd_addr = '0;
        endcase
    end

    cii_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ROWS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_ext[AW-1:0]),
        .wdata (wr_row),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_row)
    );

    // Compare results for the controller
    always_comb
    begin
        sts.below  = (wl_reg < first_row_reg.bp);
        sts.above  = (wl_reg > rd_row.bp);
        sts.hit    = (wl_reg >= prev_row_reg.bp) && (wl_reg <= rd_row.bp);
        sts.zero_w = (prev_row_reg.bp == rd_row.bp);
        sts.at_end = (cnt_reg == last_row);
    end

    // Scan and segment registers, one multiplier per part
    always_ff @(posedge clk)
    begin
        if (cmd.take_query)
        begin
            wl_reg  <= wavelength;
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + AW'(1);
        end

        if (cmd.first_cap)
        begin
            first_row_reg <= rd_row;
            prev_row_reg  <= rd_row;
        end
        else if (cmd.prev_cap)
        begin
            prev_row_reg <= rd_row;
        end

        if (cmd.seg_cap)
        begin
            b_re_reg <= rd_row.re;
            b_im_reg <= rd_row.im;
            d1_reg   <= wl_reg - prev_row_reg.bp;
            d2_reg   <= rd_row.bp - wl_reg;
            w_reg    <= rd_row.bp - prev_row_reg.bp;
        end

        if (cmd.mul_a)
        begin
            prod_re_reg <= ACW'(prev_row_reg.re) * ACW'(d2_reg);
            prod_im_reg <= ACW'(prev_row_reg.im) * ACW'(d2_reg);
        end
        else if (cmd.mul_b)
        begin
            acc_re_reg  <= prod_re_reg + ACW'(w_reg >> 1);
            acc_im_reg  <= prod_im_reg + ACW'(w_reg >> 1);
            prod_re_reg <= ACW'(b_re_reg) * ACW'(d1_reg);
            prod_im_reg <= ACW'(b_im_reg) * ACW'(d1_reg);
        end
    end

    assign num_re = acc_re_reg + prod_re_reg;
    assign num_im = acc_im_reg + prod_im_reg;

    cii_div u_div_re (
        .clk  (clk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (num_re),
        .den  (w_reg),
        .quot (quot_re)
    );

    cii_div u_div_im (
        .clk  (clk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (num_im),
        .den  (w_reg),
        .quot (quot_im)
    );

    // Result select
    always_comb
    begin
        case (cmd.res_sel)
            cii_pkg::RES_FIRST:
            begin
                res_re_next = first_row_reg.re;
                res_im_next = first_row_reg.im;
            end
            cii_pkg::RES_RDATA:
            begin
                res_re_next = rd_row.re;
                res_im_next = rd_row.im;
            end
            cii_pkg::RES_PREV:
            begin
                res_re_next = prev_row_reg.re;
                res_im_next = prev_row_reg.im;
            end
            cii_pkg::RES_ONE:
            begin
                res_re_next = ONE_VAL;
                res_im_next = '0;
            end
            cii_pkg::RES_QUOT:
            begin
                res_re_next = quot_re;
                res_im_next = quot_im;
            end
            default:
            begin
                res_re_next = ONE_VAL;
                res_im_next = '0;
            end
        endcase
    end

    // Result staging and output word
    always_ff @(posedge clk)
    begin
        if (cmd.res_cap)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            res_rc_reg <= cmd.res_rc;
        end
        if (cmd.out_load)
        begin
            out_re_reg <= res_re_reg;
            out_im_reg <= res_im_reg;
            out_rc_reg <= res_rc_reg;
        end
    end

    assign index_re   = out_re_reg;
    assign index_im   = out_im_reg;
    assign range_case = out_rc_reg;

endmodule

// ===== rtl/complex_index_interpolator.sv =====
`timescale 1ns / 1ps
// Load word: written to the table as it is taken; the next word is taken on the following cycle.
// Query: a clamped query skips the scan; otherwise the table is scanned one row per cycle until
// a segment is found or the last row is passed, and a segment of nonzero width then runs
// the 17-step divider. The next word is taken
// the cycle after the result enters the output register. rst_n (async, active low) clears
// control and output valid and sets entries_in_use to 22; the table RAM is not cleared.

module complex_index_interpolator #(
    parameter int MAX_ROWS  = 32,
    parameter int FRAC_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Config: entries_in_use
    input  logic                          cfg_we,
    input  logic [cii_pkg::CNT_W-1:0]     cfg_data,
    // Input word
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_index[4:0], wavelength[22:5], load_re[39:23], load_im[56:40], zero fill
    input  logic [cii_pkg::S_DATA_W-1:0]  s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    // Output word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // index_re[16:0], index_im[33:17], zero fill
    output logic [cii_pkg::M_DATA_W-1:0]  m_tdata,
    // range_case[1:0]
    output logic [cii_pkg::RC_W-1:0]      m_tuser
);

    localparam int IXW = cii_pkg::IX_W;

    cii_pkg::cmd_t   cmd;
    cii_pkg::sts_t   sts;
    logic [IXW-1:0]  index_re;
    logic [IXW-1:0]  index_im;

    cii_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cii_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .entry_index (s_tdata[4:0]),
        .wavelength  (s_tdata[22:5]),
        .load_re     (s_tdata[39:23]),
        .load_im     (s_tdata[56:40]),
        .cmd         (cmd),
        .sts         (sts),
        .index_re    (index_re),
        .index_im    (index_im),
        .range_case  (m_tuser)
    );

    assign m_tdata = {(cii_pkg::M_DATA_W - 2 * IXW)'(0), index_im, index_re};

endmodule

// ===== rtl/cii_checker.sv =====
`timescale 1ns / 1ps

module cii_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cii_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [cii_pkg::RC_W-1:0]      m_tuser
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // A query blocks the input for its duration
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == cii_pkg::KIND_QUERY) |=> !s_tready)
        else $error("input accepted while a query is in work");

    // Range code is one of the three defined
    a_rc_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == cii_pkg::RC_INTERP) || (m_tuser == cii_pkg::RC_BELOW)
                     || (m_tuser == cii_pkg::RC_ABOVE))
        else $error("undefined range code");

    // A new result never rises in the cycle after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared right after an accept");

endmodule

bind complex_index_interpolator cii_checker u_cii_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
